// File: rtl/core/okvt_pkg.sv
package okvt_pkg;

  // Request codes
  typedef enum logic [3:0] {
    ACT_ADD            = 4'd0,
    ACT_SET            = 4'd1,
    ACT_GET            = 4'd2,
    ACT_REMOVE         = 4'd3,
    ACT_CONTAINS       = 4'd4,
    ACT_CONTAINS_VALUE = 4'd5,
    ACT_KEY_OF         = 4'd6,
    ACT_KEY_AT         = 4'd7,
    ACT_VALUE_AT       = 4'd8,
    ACT_CLEAR          = 4'd9
  } action_t;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_KEY   = 3'd1;
  localparam logic [2:0] ST_NO_VALUE = 3'd2;
  localparam logic [2:0] ST_BAD_POS  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Result word handed from the sequencer to the output register
  typedef struct packed {
    logic        hit;
    logic [31:0] key_out;
    logic [31:0] value_out;
    logic [2:0]  status;
    logic [4:0]  entry_count;
    logic        is_empty;
  } okvt_rsp_t;

  // Write enables of the pair memory
  typedef struct packed {
    logic key_we;
    logic value_we;
  } okvt_wr_t;

endpackage

// File: rtl/core/okvt_store.sv
module okvt_store import okvt_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int KW    = 32,
  parameter int VW    = 32
) (
  input  logic          clk,
  input  okvt_wr_t      wr,
  input  logic [AW-1:0] waddr,
  input  logic [KW-1:0] wkey,
  input  logic [VW-1:0] wval,
  input  logic [AW-1:0] raddr,
  output logic [KW-1:0] rkey,
  output logic [VW-1:0] rval
);

  logic [KW-1:0] key_mem [DEPTH];
  logic [VW-1:0] val_mem [DEPTH];

  // One write port, one registered read port per array
  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[waddr] <= wkey;
    end
    if (wr.value_we) begin
      val_mem[waddr] <= wval;
    end
    rkey <= key_mem[raddr];
    rval <= val_mem[raddr];
  end

endmodule

// File: rtl/core/okvt_ctrl.sv
module okvt_ctrl import okvt_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [3:0]             action,
  input  logic [31:0]            req_key,
  input  logic [31:0]            req_value,
  input  logic [3:0]             position,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output okvt_rsp_t              rsp,
  output okvt_wr_t               wr,
  output logic [AW-1:0]          waddr,
  output logic [KEY_WIDTH-1:0]   wkey,
  output logic [VALUE_WIDTH-1:0] wval,
  output logic [AW-1:0]          raddr,
  input  logic [KEY_WIDTH-1:0]   rkey,
  input  logic [VALUE_WIDTH-1:0] rval
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 4) ? CW : 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_RESP
  } state_t;

  state_t                 state;
  action_t                act;
  logic [KEY_WIDTH-1:0]   k;
  logic [VALUE_WIDTH-1:0] v;
  logic [CW-1:0]          cur;
  logic [CW-1:0]          count;
  logic                   hit_r;
  logic [31:0]            kout_r;
  logic [31:0]            vout_r;
  logic [2:0]             status_r;

  logic [CW-1:0] nxt;
  logic          match;
  logic          found;
  logic          at_end;
  logic          pos_ok;
  logic          full;

  // Compare the entry now on the read port against the request
  always_comb begin
    nxt    = cur + CW'(1);
    match  = ((act == ACT_CONTAINS_VALUE) || (act == ACT_KEY_OF)) ? (rval == v) : (rkey == k);
    found  = match && (cur < count);
    at_end = (nxt >= count);
    pos_ok = PW'(position) < PW'(count);
    full   = (count == CW'(CAPACITY));
  end

  // Memory port control
  always_comb begin
    wr    = '0;
    waddr = AW'(cur);
    wkey  = k;
    wval  = v;
    raddr = AW'(nxt);
    case (state)
      S_IDLE: begin
        raddr = (action == ACT_KEY_AT || action == ACT_VALUE_AT) ? AW'(position) : '0;
      end
      S_SCAN: begin
        if (found) begin
          wr.value_we = (act == ACT_ADD) || (act == ACT_SET);
        end else if (at_end && act == ACT_ADD && !full) begin
          wr.key_we   = 1'b1;
          wr.value_we = 1'b1;
          waddr       = AW'(count);
        end
      end
      S_SHIFT: begin
        // move the entry just read down one slot
        wr.key_we   = 1'b1;
        wr.value_we = 1'b1;
        waddr       = AW'(cur - CW'(1));
        wkey        = rkey;
        wval        = rval;
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign rsp_valid = (state == S_RESP);

  always_comb begin
    rsp.hit         = hit_r;
    rsp.key_out     = kout_r;
    rsp.value_out   = vout_r;
    rsp.status      = status_r;
    rsp.entry_count = 5'(count);
    rsp.is_empty    = (count == '0);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act      <= action_t'(action);
            k        <= KEY_WIDTH'(req_key);
            v        <= VALUE_WIDTH'(req_value);
            cur      <= '0;
            hit_r    <= 1'b0;
            kout_r   <= '0;
            vout_r   <= '0;
            status_r <= ST_OK;
            case (action)
              ACT_ADD, ACT_SET, ACT_GET, ACT_REMOVE, ACT_CONTAINS,
              ACT_CONTAINS_VALUE, ACT_KEY_OF: begin
                state <= S_SCAN;
              end
              ACT_KEY_AT, ACT_VALUE_AT: begin
                if (pos_ok) begin
                  state <= S_READ;
                end else begin
                  status_r <= ST_BAD_POS;
                  state    <= S_RESP;
                end
              end
              ACT_CLEAR: begin
                count <= '0;
                state <= S_RESP;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (found) begin
            hit_r <= 1'b1;
            state <= S_RESP;
            case (act)
              ACT_GET:    vout_r <= 32'(rval);
              ACT_KEY_OF: kout_r <= 32'(rkey);
              ACT_REMOVE: begin
                if (nxt < count) begin
                  cur   <= nxt;
                  state <= S_SHIFT;
                end else begin
                  count <= count - CW'(1);
                end
              end
              default: begin
              end
            endcase
          end else if (at_end) begin
            state <= S_RESP;
            case (act)
              ACT_ADD: begin
                if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              ACT_SET, ACT_GET, ACT_REMOVE: status_r <= ST_NO_KEY;
              ACT_KEY_OF:                   status_r <= ST_NO_VALUE;
              default: begin
              end
            endcase
          end else begin
            cur <= nxt;
          end
        end
        S_SHIFT: begin
          if (nxt < count) begin
            cur <= nxt;
          end else begin
            count <= count - CW'(1);
            state <= S_RESP;
          end
        end
        S_READ: begin
          hit_r <= 1'b1;
          if (act == ACT_KEY_AT) begin
            kout_r <= 32'(rkey);
          end else begin
            vout_r <= 32'(rval);
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/ordered_key_value_table.sv
// A search reads the entries in order until a match or the end of the fill count; remove
// then shifts each later entry down one slot; key_at and value_at read the addressed entry.
// One word is in work at a time, as the sequencer takes a word only while idle; the
// next word is taken once the result moves into the output register.
// Reset clears the fill count, sequencer and output valid; the pair memory is not
// cleared, and entries at or above the fill count are never reported.
module ordered_key_value_table import okvt_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  action,
  input  logic [31:0] req_key,
  input  logic [31:0] req_value,
  input  logic [3:0]  position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [31:0] key_out,
  output logic [31:0] value_out,
  output logic [2:0]  status,
  output logic [4:0]  entry_count,
  output logic        is_empty
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  okvt_rsp_t              rsp;
  logic                   rsp_valid;
  logic                   rsp_ready;
  okvt_wr_t               wr;
  logic [AW-1:0]          waddr;
  logic [KEY_WIDTH-1:0]   wkey;
  logic [VALUE_WIDTH-1:0] wval;
  logic [AW-1:0]          raddr;
  logic [KEY_WIDTH-1:0]   rkey;
  logic [VALUE_WIDTH-1:0] rval;

  okvt_ctrl #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .req_key   (req_key),
    .req_value (req_value),
    .position  (position),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .wr        (wr),
    .waddr     (waddr),
    .wkey      (wkey),
    .wval      (wval),
    .raddr     (raddr),
    .rkey      (rkey),
    .rval      (rval)
  );

  okvt_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .KW    (KEY_WIDTH),
    .VW    (VALUE_WIDTH)
  ) u_store (
    .clk   (clk),
    .wr    (wr),
    .waddr (waddr),
    .wkey  (wkey),
    .wval  (wval),
    .raddr (raddr),
    .rkey  (rkey),
    .rval  (rval)
  );

  // Output register: frees the sequencer while a result waits
  assign rsp_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      hit         <= rsp.hit;
      key_out     <= rsp.key_out;
      value_out   <= rsp.value_out;
      status      <= rsp.status;
      entry_count <= rsp.entry_count;
      is_empty    <= rsp.is_empty;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer still ready after taking a word");

  a_hit_is_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> status == ST_OK)
    else $error("hit reported with an error status");

  a_rsp_lands: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready |=> out_valid)
    else $error("handed-off result missing from output register");

endmodule

// File: dv/ordered_key_value_table_chk.sv
module ordered_key_value_table_chk import okvt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  action,
  input  logic [31:0] req_key,
  input  logic [31:0] req_value,
  input  logic [3:0]  position,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        hit,
  input  logic [31:0] key_out,
  input  logic [31:0] value_out,
  input  logic [2:0]  status,
  input  logic [4:0]  entry_count,
  input  logic        is_empty,
  output int          err_count,
  output int          pending
);

  localparam int SLOTS = 16;

  // shadow copy of the pair table
  logic [31:0] slot_key [SLOTS];
  logic [31:0] slot_val [SLOTS];
  int          fill;
  okvt_rsp_t   answers_due [$];

  initial begin
    err_count = 0;
    pending   = 0;
    fill      = 0;
  end

  // first position holding the key, -1 when absent
  function automatic int key_pos(input logic [31:0] k);
    for (int i = 0; i < fill; i++)
      if (slot_key[i] == k) return i;
    return -1;
  endfunction

  // first position holding the value, -1 when absent
  function automatic int val_pos(input logic [31:0] v);
    for (int i = 0; i < fill; i++)
      if (slot_val[i] == v) return i;
    return -1;
  endfunction

  // apply one request to the shadow table and build its answer
  function automatic okvt_rsp_t apply_request(input logic [3:0] act, input logic [31:0] k,
                                              input logic [31:0] v, input logic [3:0] p);
    okvt_rsp_t r;
    int        at;
    r = '0;
    case (act)
      ACT_ADD: begin
        at = key_pos(k);
        if (at >= 0) begin
          slot_val[at] = v;
          r.hit = 1'b1;
        end else if (fill >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          slot_key[fill] = k;
          slot_val[fill] = v;
          fill++;
        end
      end
      ACT_SET: begin
        at = key_pos(k);
        if (at >= 0) begin
          slot_val[at] = v;
          r.hit = 1'b1;
        end else begin
          r.status = ST_NO_KEY;
        end
      end
      ACT_GET: begin
        at = key_pos(k);
        if (at >= 0) begin
          r.value_out = slot_val[at];
          r.hit = 1'b1;
        end else begin
          r.status = ST_NO_KEY;
        end
      end
      ACT_REMOVE: begin
        at = key_pos(k);
        if (at >= 0) begin
          // close the gap
          for (int j = at; j < fill - 1; j++) begin
            slot_key[j] = slot_key[j + 1];
            slot_val[j] = slot_val[j + 1];
          end
          fill--;
          r.hit = 1'b1;
        end else begin
          r.status = ST_NO_KEY;
        end
      end
      ACT_CONTAINS:       r.hit = (key_pos(k) >= 0);
      ACT_CONTAINS_VALUE: r.hit = (val_pos(v) >= 0);
      ACT_KEY_OF: begin
        at = val_pos(v);
        if (at >= 0) begin
          r.key_out = slot_key[at];
          r.hit = 1'b1;
        end else begin
          r.status = ST_NO_VALUE;
        end
      end
      ACT_KEY_AT: begin
        if (int'(p) < fill) begin
          r.key_out = slot_key[p];
          r.hit = 1'b1;
        end else begin
          r.status = ST_BAD_POS;
        end
      end
      ACT_VALUE_AT: begin
        if (int'(p) < fill) begin
          r.value_out = slot_val[p];
          r.hit = 1'b1;
        end else begin
          r.status = ST_BAD_POS;
        end
      end
      ACT_CLEAR: fill = 0;
      default: ;
    endcase
    r.entry_count = 5'(fill);
    r.is_empty    = (fill == 0);
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    err_count++;
    $display("[%0t] mismatch on %s: got 0x%h, want 0x%h", $time, what, got, want);
  endtask

  // watch both channels; predict on input words, compare on output words
  always @(posedge clk) begin : watch
    okvt_rsp_t want;
    if (rst) begin
      fill = 0;
      answers_due.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready)
        answers_due.push_back(apply_request(action, req_key, req_value, position));
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          report("unexpected word", 32'd0, 32'd0);
        end else begin
          want = answers_due.pop_front();
          if (hit !== want.hit)                 report("hit", 32'(hit), 32'(want.hit));
          if (key_out !== want.key_out)         report("key_out", key_out, want.key_out);
          if (value_out !== want.value_out)     report("value_out", value_out, want.value_out);
          if (status !== want.status)           report("status", 32'(status), 32'(want.status));
          if (entry_count !== want.entry_count)
            report("entry_count", 32'(entry_count), 32'(want.entry_count));
          if (is_empty !== want.is_empty)
            report("is_empty", 32'(is_empty), 32'(want.is_empty));
        end
      end
      pending <= answers_due.size();
    end
  end

endmodule

// File: dv/ordered_key_value_table_tb.sv
module ordered_key_value_table_tb;
  import okvt_pkg::*;

  localparam int          N_ITEMS    = 550;
  localparam int          LIMIT      = 400000;
  localparam int          HOLD_OFF   = 300;
  localparam logic [3:0]  ACT_SPARE_LO = 4'd10;
  localparam logic [3:0]  ACT_SPARE_HI = 4'd15;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid, in_ready;
  logic [3:0]  action;
  logic [31:0] req_key, req_value;
  logic [3:0]  position;
  logic        out_valid, out_ready;
  logic        hit;
  logic [31:0] key_out, value_out;
  logic [2:0]  status;
  logic [4:0]  entry_count;
  logic        is_empty;

  int          err_count, pending;
  int          sent = 0;
  int          gap_pct = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  logic [31:0] key_pool [24];
  logic [31:0] val_pool [6];

  ordered_key_value_table dut (
    .clk, .rst, .in_valid, .in_ready, .action, .req_key, .req_value, .position,
    .out_valid, .out_ready, .hit, .key_out, .value_out, .status, .entry_count, .is_empty
  );

  ordered_key_value_table_chk chk (
    .clk, .rst, .in_valid, .in_ready, .action, .req_key, .req_value, .position,
    .out_valid, .out_ready, .hit, .key_out, .value_out, .status, .entry_count, .is_empty,
    .err_count, .pending
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("[ordered_key_value_table] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return key_pool[$urandom_range(0, 23)];
  endfunction

  function automatic logic [31:0] pick_val();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return val_pool[$urandom_range(0, 5)];
  endfunction

  // offer one word, with an occasional gap in front; returns at the accepting edge
  task automatic send_word(input logic [3:0] act, input logic [31:0] k,
                           input logic [31:0] v, input logic [3:0] p);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    req_key   <= k;
    req_value <= v;
    position  <= p;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent++;
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin : drain_side
    int  tick;
    int  recv_pct;
    bit  held;
    tick = 0;
    recv_pct = 10;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (!held && sent >= 80) begin
        held = 1'b1;
        out_ready <= 1'b0;
        for (int c = 0; c < HOLD_OFF; c++) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 99) < recv_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      tick++;
      if (tick % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       recv_pct = 0;
          1:       recv_pct = 8;
          default: recv_pct = 25;
        endcase
      end
    end
  end

  initial begin : source_side
    int         seq_no;
    int         kind;
    int         r;
    logic [3:0] act;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    action    <= ACT_ADD;
    req_key   <= '0;
    req_value <= '0;
    position  <= '0;
    // distinct low bits keep the pool keys unique
    foreach (key_pool[i]) key_pool[i] = ($urandom & 32'hFFFF_FFE0) | 32'(i);
    foreach (val_pool[i]) val_pool[i] = $urandom;
    val_pool[0] = 32'h0000_0000;
    val_pool[1] = 32'hFFFF_FFFF;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-table misses, field extremes, duplicates, shifting remove
    gap_pct = 15;
    send_word(ACT_GET,            32'h0000_0000, 32'h0000_0000, 4'd0);
    send_word(ACT_KEY_AT,         32'h0000_0000, 32'h0000_0000, 4'd0);
    send_word(ACT_VALUE_AT,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_word(ACT_KEY_OF,         32'h0000_0000, 32'h0000_0000, 4'd0);
    send_word(ACT_CONTAINS_VALUE, 32'h0000_0000, 32'h0000_0000, 4'd0);
    send_word(ACT_CONTAINS,       32'h0000_0000, 32'h0000_0000, 4'd0);
    send_word(ACT_REMOVE,         32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
    send_word(ACT_SET,            32'h0000_0000, 32'h1234_5678, 4'd0);
    send_word(ACT_CLEAR,          32'h0000_0000, 32'h0000_0000, 4'd0);
    send_word(ACT_ADD,            32'h0000_0000, 32'hFFFF_FFFF, 4'd0);
    send_word(ACT_ADD,            32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
    send_word(ACT_ADD,            32'h0000_0000, 32'h0000_0000, 4'd0);
    send_word(ACT_ADD,            32'hA5A5_A5A5, 32'h0000_0000, 4'd0);
    // three pairs share value zero: lowest position wins
    send_word(ACT_KEY_OF,         32'h0000_0000, 32'h0000_0000, 4'd0);
    send_word(ACT_CONTAINS_VALUE, 32'h0000_0000, 32'hFFFF_FFFF, 4'd0);
    send_word(ACT_GET,            32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
    send_word(ACT_SET,            32'hFFFF_FFFF, 32'h5A5A_5A5A, 4'd0);
    send_word(ACT_KEY_AT,         32'h0000_0000, 32'h0000_0000, 4'd2);
    send_word(ACT_VALUE_AT,       32'h0000_0000, 32'h0000_0000, 4'd1);
    send_word(ACT_REMOVE,         32'h0000_0000, 32'h0000_0000, 4'd0);
    send_word(ACT_KEY_AT,         32'h0000_0000, 32'h0000_0000, 4'd0);
    send_word(ACT_SPARE_LO,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd3);
    send_word(ACT_SPARE_HI,       32'h0000_0000, 32'h0000_0000, 4'd15);
    send_word(ACT_CLEAR,          32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_word(ACT_CONTAINS,       32'hA5A5_A5A5, 32'h0000_0000, 4'd0);

    // random sequences
    seq_no = 0;
    while (sent < N_ITEMS) begin
      if (sent >= N_ITEMS - 60) quiet = 1'b1;
      case ($urandom_range(0, 3))
        0:       gap_pct = 0;
        1:       gap_pct = 5;
        2:       gap_pct = 20;
        default: gap_pct = 40;
      endcase
      kind = (seq_no == 0) ? 0 : $urandom_range(0, 9);
      seq_no++;
      if (kind <= 1) begin
        // fill to capacity, then push past it
        send_word(ACT_CLEAR, pick_key(), pick_val(), 4'($urandom));
        for (int i = 0; i < 16; i++)
          send_word(ACT_ADD, key_pool[i], pick_val(), 4'($urandom));
        for (int i = 16; i < 19; i++)
          send_word(ACT_ADD, key_pool[i], pick_val(), 4'($urandom));
        send_word(ACT_ADD, key_pool[$urandom_range(0, 15)], pick_val(), 4'($urandom));
        send_word(ACT_KEY_AT, pick_key(), pick_val(), 4'd15);
        send_word(ACT_VALUE_AT, pick_key(), pick_val(), 4'($urandom));
        send_word(ACT_KEY_OF, pick_key(), pick_val(), 4'($urandom));
        send_word(ACT_REMOVE, key_pool[$urandom_range(0, 15)], pick_val(), 4'($urandom));
      end else if (kind <= 6) begin
        // mixed operations over the key and value pools
        repeat (20) begin
          r = $urandom_range(0, 99);
          if      (r < 25) act = ACT_ADD;
          else if (r < 33) act = ACT_SET;
          else if (r < 45) act = ACT_GET;
          else if (r < 55) act = ACT_REMOVE;
          else if (r < 63) act = ACT_CONTAINS;
          else if (r < 70) act = ACT_CONTAINS_VALUE;
          else if (r < 78) act = ACT_KEY_OF;
          else if (r < 87) act = ACT_KEY_AT;
          else if (r < 96) act = ACT_VALUE_AT;
          else             act = ACT_CLEAR;
          send_word(act, pick_key(), pick_val(), 4'($urandom));
        end
      end else if (kind <= 8) begin
        // removals with position reads in between
        repeat (10) begin
          send_word(ACT_REMOVE, key_pool[$urandom_range(0, 23)], pick_val(), 4'($urandom));
          send_word($urandom_range(0, 1) ? ACT_KEY_AT : ACT_VALUE_AT,
                    pick_key(), pick_val(), 4'($urandom));
        end
      end else begin
        // noise: any code, any bits
        repeat (8)
          send_word(4'($urandom), $urandom, $urandom, 4'($urandom));
      end
    end

    // drain and give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("[ordered_key_value_table] OK");
    end else begin
      $display("[ordered_key_value_table] ERROR");
    end
    $finish;
  end

endmodule
